### rtl/slice_free_list_allocator_top_defines.svh
// Assertion macros used by the allocator datapath.
`ifndef SLICE_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define SLICE_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SFLA_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("allocator assertion failed");
// Next-cycle implication, disabled during reset.
`define SFLA_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("allocator assertion failed");
`else
`define SFLA_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define SFLA_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

### rtl/sfla_pkg.sv
package sfla_pkg;

  // Default sizes.
  localparam int FREE_ENTRIES_DEF   = 64;
  localparam int INDEX_BITS_DEF     = 20;
  localparam int RING_SLOTS_DEF     = 3;
  localparam int DEFERRED_DEPTH_DEF = 32;

  // Fixed field widths.
  localparam int BYTES_W   = 23;
  localparam int CFG_IDX_W = 2;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;

  // Register reset values.
  localparam int POOL_RESET = 65536;
  localparam int ISB_RESET  = 2;
  localparam int CAND_RESET = 10;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ISB  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAND = 2'd2;

  // Actions.
  localparam logic [ACT_W-1:0] ACT_GET    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RET    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RETGET = 2'd2;
  localparam logic [ACT_W-1:0] ACT_EOF    = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_RET, CMD_SCAN, CMD_EX_RD, CMD_EX_WR, CMD_FIT,
    CMD_NOFIT, CMD_SORT_INIT, CMD_KEY_RD, CMD_KEY_LD, CMD_IN_CHK, CMD_IN_CMP,
    CMD_MG_INIT, CMD_MG_LD, CMD_MG_CHK, CMD_MG_CMP, CMD_SH_CHK, CMD_SH_WR,
    CMD_MG_DONE, CMD_EF_SLOT, CMD_EF_CHK, CMD_EF_REL, CMD_OUT
  } cmd_t;

  // Status flags returned to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic num_zero;
    logic merge_go;
    logic scan_done;
    logic exact;
    logic has_cand;
    logic i_lt_used;
    logic j_zero;
    logic shift;
    logic ip1_lt_used;
    logic mergeable;
    logic jp1_lt_used;
    logic k_lt_dused;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/sfla_if.sv
// Request channel.
interface sfla_in_if #(parameter int INDEX_BITS = sfla_pkg::INDEX_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic [sfla_pkg::ACT_W-1:0]   action;
  logic [INDEX_BITS:0]          num_ids;
  logic [INDEX_BITS-1:0]        slice_start;
  logic [INDEX_BITS:0]          slice_length;
  modport source(output valid, action, num_ids, slice_start, slice_length, input ready);
  modport sink(input valid, action, num_ids, slice_start, slice_length, output ready);
endinterface

// Result channel.
interface sfla_out_if #(
  parameter int INDEX_BITS   = sfla_pkg::INDEX_BITS_DEF,
  parameter int FREE_ENTRIES = sfla_pkg::FREE_ENTRIES_DEF
);
  logic                                valid;
  logic                                ready;
  logic [sfla_pkg::STAT_W-1:0]         status;
  logic [INDEX_BITS-1:0]               granted_start;
  logic [INDEX_BITS:0]                 granted_length;
  logic [sfla_pkg::BYTES_W-1:0]        allocated_bytes;
  logic [$clog2(FREE_ENTRIES+1)-1:0]   free_count;
  modport source(output valid, status, granted_start, granted_length, allocated_bytes,
                 free_count, input ready);
  modport sink(input valid, status, granted_start, granted_length, allocated_bytes,
               free_count, output ready);
endinterface

### rtl/sfla_dp.sv
`include "slice_free_list_allocator_top_defines.svh"
module sfla_dp #(
  parameter int FREE_ENTRIES   = sfla_pkg::FREE_ENTRIES_DEF,
  parameter int INDEX_BITS     = sfla_pkg::INDEX_BITS_DEF,
  parameter int RING_SLOTS     = sfla_pkg::RING_SLOTS_DEF,
  parameter int DEFERRED_DEPTH = sfla_pkg::DEFERRED_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sfla_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [INDEX_BITS:0]                 cfg_data,
  input  logic [sfla_pkg::ACT_W-1:0]          in_action,
  input  logic [INDEX_BITS:0]                 in_num,
  input  logic [INDEX_BITS-1:0]               in_start,
  input  logic [INDEX_BITS:0]                 in_len,
  input  sfla_pkg::cmd_t                      cmd,
  output sfla_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sfla_pkg::STAT_W-1:0]         out_status,
  output logic [INDEX_BITS-1:0]               out_gstart,
  output logic [INDEX_BITS:0]                 out_glen,
  output logic [sfla_pkg::BYTES_W-1:0]        out_bytes,
  output logic [$clog2(FREE_ENTRIES+1)-1:0]   out_count
);
  import sfla_pkg::*;

  localparam int IB    = INDEX_BITS;
  localparam int LW    = INDEX_BITS + 1;
  localparam int AW    = $clog2(FREE_ENTRIES);
  localparam int UW    = $clog2(FREE_ENTRIES + 1);
  localparam int CW    = (DEFERRED_DEPTH > 1) ? $clog2(DEFERRED_DEPTH) : 1;
  localparam int DW    = $clog2(DEFERRED_DEPTH + 1);
  localparam int SLW   = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int DAW   = SLW + CW;
  localparam int DDEPTH = 1 << DAW;
  localparam int PW    = LW + 3;
  localparam int SW    = ((PW > BYTES_W) ? PW : BYTES_W) + 1;

  // Configuration registers.
  logic [LW-1:0] pool_ids;
  logic [2:0]    isb;
  logic [4:0]    cand_lim;

  // Free table memory and its read register.
  logic [IB-1:0] fm_s [FREE_ENTRIES];
  logic [LW-1:0] fm_l [FREE_ENTRIES];
  logic [IB-1:0] rd_s;
  logic [LW-1:0] rd_l;
  logic          rd_ovr;
  logic          e0_valid;

  // Deferred list memory and its read register.
  logic [IB-1:0] dm_s [DDEPTH];
  logic [LW-1:0] dm_l [DDEPTH];
  logic [IB-1:0] drd_s;
  logic [LW-1:0] drd_l;

  // Allocator state.
  logic [UW-1:0]  used;
  logic [DW-1:0]  dused [RING_SLOTS];
  logic [SLW-1:0] ring;
  logic [BYTES_W-1:0] bytes;
  logic           nm;

  // Current word and loop registers.
  logic [ACT_W-1:0]  act;
  logic [LW-1:0]     num;
  logic [IB-1:0]     ss;
  logic [LW-1:0]     sl;
  logic [STAT_W-1:0] st;
  logic [IB-1:0]     gs;
  logic [LW-1:0]     gl;
  logic [UW-1:0]     i_idx, j_idx;
  logic [AW-1:0]     ev_idx, best_idx;
  logic              pend, stop, exact;
  logic [4:0]        cnt;
  logic [IB-1:0]     best_s, key_s, cur_s;
  logic [LW-1:0]     best_l, key_l, cur_l;
  logic [DW-1:0]     k_idx;

  // Combinational helpers.
  logic [IB-1:0] fs_rd;
  logic [LW-1:0] fl_rd;
  logic [UW-1:0] ip1, jp1, jm1, used_m1;
  logic          i_lt_used, scan_done, used_lt_fe, ret_ok, mergeable, shift;
  logic [DW-1:0] dcur;
  logic [LW:0]   lsum;
  logic [LW-1:0] mul_a;
  logic [PW-1:0] prod;
  logic [SW-1:0] bsum;
  logic [BYTES_W-1:0] bytes_add, bytes_sub;
  logic          ev_eq, ev_gt;

  logic          re, we, dre, dwe;
  logic [AW-1:0] ra, wa;
  logic [IB-1:0] ws;
  logic [LW-1:0] wl;
  logic [DAW-1:0] dra, dwa;

  // Entry zero reads as the whole pool until it is first written.
  assign fs_rd = rd_ovr ? '0 : rd_s;
  assign fl_rd = rd_ovr ? pool_ids : rd_l;

  assign ip1        = i_idx + 1'b1;
  assign jp1        = j_idx + 1'b1;
  assign jm1        = j_idx - 1'b1;
  assign used_m1    = used - 1'b1;
  assign i_lt_used  = i_idx < used;
  assign scan_done  = stop || (!i_lt_used && !pend);
  assign used_lt_fe = used < UW'(FREE_ENTRIES);
  assign dcur       = dused[ring];
  assign ret_ok     = (pool_ids != '0) && (dcur < DW'(DEFERRED_DEPTH));
  assign lsum       = {1'b0, cur_l} + {1'b0, fl_rd};
  assign mergeable  = (({2'b00, cur_s} + {1'b0, cur_l}) == {2'b00, fs_rd}) && !lsum[LW];
  assign shift      = fs_rd > key_s;
  assign ev_eq      = fl_rd == num;
  assign ev_gt      = fl_rd > num;

  // Shared byte-total multiplier with saturating add and floored subtract.
  assign mul_a     = (cmd == CMD_EF_REL) ? drd_l : num;
  assign prod      = PW'(mul_a) * PW'(isb);
  assign bsum      = SW'(bytes) + SW'(prod);
  assign bytes_add = (bsum > SW'({BYTES_W{1'b1}})) ? {BYTES_W{1'b1}} : bsum[BYTES_W-1:0];
  assign bytes_sub = (SW'(prod) > SW'(bytes)) ? '0 : BYTES_W'(SW'(bytes) - SW'(prod));

  // Status to the controller.
  always_comb begin
    stat.act         = act;
    stat.num_zero    = num == '0;
    stat.merge_go    = nm && (used > UW'(1));
    stat.scan_done   = scan_done;
    stat.exact       = exact;
    stat.has_cand    = cnt != '0;
    stat.i_lt_used   = i_lt_used;
    stat.j_zero      = j_idx == '0;
    stat.shift       = shift;
    stat.ip1_lt_used = ip1 < used;
    stat.mergeable   = mergeable;
    stat.jp1_lt_used = jp1 < used;
    stat.k_lt_dused  = k_idx < dcur;
    stat.out_free    = !out_valid || out_ready;
  end

  // Free table port control for each micro-operation.
  always_comb begin
    re = 1'b0;
    ra = '0;
    we = 1'b0;
    wa = '0;
    ws = '0;
    wl = '0;
    unique case (cmd)
      CMD_SCAN: begin
        if (!scan_done && i_lt_used) begin
          re = 1'b1;
          ra = i_idx[AW-1:0];
        end
      end
      CMD_EX_RD: begin
        re = 1'b1;
        ra = used_m1[AW-1:0];
      end
      CMD_EX_WR: begin
        we = 1'b1;
        wa = best_idx;
        ws = fs_rd;
        wl = fl_rd;
      end
      CMD_FIT: begin
        we = 1'b1;
        wa = best_idx;
        ws = best_s + num[IB-1:0];
        wl = best_l - num;
      end
      CMD_KEY_RD: begin
        re = 1'b1;
        ra = i_idx[AW-1:0];
      end
      CMD_IN_CHK: begin
        if (j_idx == '0) begin
          we = 1'b1;
          wa = '0;
          ws = key_s;
          wl = key_l;
        end else begin
          re = 1'b1;
          ra = jm1[AW-1:0];
        end
      end
      CMD_IN_CMP: begin
        we = 1'b1;
        wa = j_idx[AW-1:0];
        ws = shift ? fs_rd : key_s;
        wl = shift ? fl_rd : key_l;
      end
      CMD_MG_INIT: begin
        re = 1'b1;
        ra = '0;
      end
      CMD_MG_CHK: begin
        if (ip1 < used) begin
          re = 1'b1;
          ra = ip1[AW-1:0];
        end
      end
      CMD_MG_CMP: begin
        if (mergeable) begin
          we = 1'b1;
          wa = i_idx[AW-1:0];
          ws = cur_s;
          wl = lsum[LW-1:0];
        end
      end
      CMD_SH_CHK: begin
        if (jp1 < used) begin
          re = 1'b1;
          ra = jp1[AW-1:0];
        end
      end
      CMD_SH_WR: begin
        we = 1'b1;
        wa = j_idx[AW-1:0];
        ws = fs_rd;
        wl = fl_rd;
      end
      CMD_EF_REL: begin
        if ((drd_l != '0) && used_lt_fe) begin
          we = 1'b1;
          wa = used[AW-1:0];
          ws = drd_s;
          wl = drd_l;
        end
      end
      default: ;
    endcase
  end

  // Deferred list port control.
  assign dwe = (cmd == CMD_RET) && ret_ok;
  assign dwa = {ring, dcur[CW-1:0]};
  assign dre = (cmd == CMD_EF_CHK) && (k_idx < dcur);
  assign dra = {ring, k_idx[CW-1:0]};

  // Free table memory.
  always_ff @(posedge clk) begin
    if (we) begin
      fm_s[wa] <= ws;
      fm_l[wa] <= wl;
    end
    if (re) begin
      rd_s   <= fm_s[ra];
      rd_l   <= fm_l[ra];
      rd_ovr <= (ra == '0) && !e0_valid;
    end
  end

  // Deferred list memory.
  always_ff @(posedge clk) begin
    if (dwe) begin
      dm_s[dwa] <= ss;
      dm_l[dwa] <= sl;
    end
    if (dre) begin
      drd_s <= dm_s[dra];
      drd_l <= dm_l[dra];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_ids <= LW'(POOL_RESET);
      isb      <= 3'(ISB_RESET);
      cand_lim <= 5'(CAND_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL: pool_ids <= cfg_data;
        CFG_ISB:  isb      <= cfg_data[2:0];
        CFG_CAND: cand_lim <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Allocator state; a pool write reloads it as reset does.
  always_ff @(posedge clk) begin
    if (rst || (cfg_we && (cfg_index == CFG_POOL))) begin
      used     <= UW'(1);
      e0_valid <= 1'b0;
      ring     <= '0;
      bytes    <= '0;
      nm       <= 1'b0;
      for (int r = 0; r < RING_SLOTS; r++) begin
        dused[r] <= '0;
      end
    end else begin
      if (we && (wa == '0)) begin
        e0_valid <= 1'b1;
      end
      unique case (cmd)
        CMD_RET: begin
          if (ret_ok) begin
            dused[ring] <= dcur + 1'b1;
          end
        end
        CMD_EX_WR: begin
          used  <= used_m1;
          nm    <= 1'b1;
          bytes <= bytes_add;
        end
        CMD_FIT: begin
          nm    <= 1'b1;
          bytes <= bytes_add;
        end
        CMD_SH_CHK: begin
          if (!(jp1 < used)) begin
            used <= used_m1;
          end
        end
        CMD_MG_DONE: nm <= 1'b0;
        CMD_EF_SLOT: ring <= (ring == '0) ? SLW'(RING_SLOTS - 1) : ring - 1'b1;
        CMD_EF_CHK: begin
          if (!(k_idx < dcur)) begin
            dused[ring] <= '0;
          end
        end
        CMD_EF_REL: begin
          bytes <= bytes_sub;
          if ((drd_l != '0) && used_lt_fe) begin
            used <= used + 1'b1;
            nm   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result word valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Word capture, table walks and result assembly.
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        act   <= in_action;
        num   <= in_num;
        ss    <= in_start;
        sl    <= in_len;
        st    <= ST_OK;
        gs    <= '0;
        gl    <= '0;
        i_idx <= '0;
        pend  <= 1'b0;
        stop  <= 1'b0;
        exact <= 1'b0;
        cnt   <= '0;
      end
      CMD_RET: begin
        if (pool_ids == '0) begin
          st <= ST_EMPTY;
        end else if (!ret_ok) begin
          st <= ST_FULL;
        end
      end
      CMD_SCAN: begin
        if (!scan_done) begin
          pend <= i_lt_used;
          if (i_lt_used) begin
            i_idx  <= ip1;
            ev_idx <= i_idx[AW-1:0];
          end
          // Judge the entry read in the previous cycle.
          if (pend) begin
            if (ev_eq) begin
              exact    <= 1'b1;
              stop     <= 1'b1;
              best_idx <= ev_idx;
              best_s   <= fs_rd;
            end else if (ev_gt) begin
              if ((cnt == '0) || (fl_rd < best_l)) begin
                best_idx <= ev_idx;
                best_s   <= fs_rd;
                best_l   <= fl_rd;
              end
              cnt <= cnt + 1'b1;
              if (({1'b0, cnt} + 6'd1) >= {1'b0, cand_lim}) begin
                stop <= 1'b1;
              end
            end
          end
        end
      end
      CMD_EX_WR, CMD_FIT: begin
        gs <= best_s;
        gl <= num;
      end
      CMD_NOFIT: begin
        st <= ST_NOFIT;
        gs <= '0;
        gl <= '0;
      end
      CMD_SORT_INIT: i_idx <= UW'(1);
      CMD_KEY_LD: begin
        key_s <= fs_rd;
        key_l <= fl_rd;
        j_idx <= i_idx;
      end
      CMD_IN_CHK: begin
        if (j_idx == '0) begin
          i_idx <= ip1;
        end
      end
      CMD_IN_CMP: begin
        if (shift) begin
          j_idx <= jm1;
        end else begin
          i_idx <= ip1;
        end
      end
      CMD_MG_INIT: i_idx <= '0;
      CMD_MG_LD: begin
        cur_s <= fs_rd;
        cur_l <= fl_rd;
      end
      CMD_MG_CMP: begin
        if (mergeable) begin
          cur_l <= lsum[LW-1:0];
          j_idx <= ip1;
        end else begin
          i_idx <= ip1;
          cur_s <= fs_rd;
          cur_l <= fl_rd;
        end
      end
      CMD_SH_WR: j_idx <= jp1;
      CMD_EF_SLOT: k_idx <= '0;
      CMD_EF_REL: begin
        k_idx <= k_idx + 1'b1;
        if ((drd_l != '0) && !used_lt_fe) begin
          st <= ST_FULL;
        end
      end
      CMD_OUT: begin
        out_status <= st;
        out_gstart <= gs;
        out_glen   <= gl;
        out_bytes  <= bytes;
        out_count  <= used;
      end
      default: ;
    endcase
  end

  `SFLA_ASSERT_IMP(a_used_bound, clk, rst, 1'b1, used <= UW'(FREE_ENTRIES))
  `SFLA_ASSERT_IMP(a_out_slot_free, clk, rst, cmd == CMD_OUT, !out_valid || out_ready)
  `SFLA_ASSERT_NXT(a_reload_one, clk, rst, cfg_we && (cfg_index == CFG_POOL), used == UW'(1))

endmodule

### rtl/sfla_ctrl.sv
module sfla_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  sfla_pkg::dp_stat_t stat,
  output logic               in_ready,
  output sfla_pkg::cmd_t     cmd
);
  import sfla_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_RET, S_SCAN, S_EX_RD, S_EX_WR, S_FIT, S_NOFIT,
    S_SORT_CHK, S_KEY_RD, S_KEY_LD, S_IN_CHK, S_IN_CMP,
    S_MG_INIT, S_MG_LD, S_MG_CHK, S_MG_CMP, S_SH_CHK, S_SH_WR, S_MG_DONE,
    S_EF_SLOT, S_EF_CHK, S_EF_REL, S_OUT
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  // Sequencing of micro-operations.
  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        priority if (stat.act == ACT_GET) begin
          state_next = S_SCAN;
        end else if (stat.act == ACT_EOF) begin
          cmd        = CMD_SORT_INIT;
          state_next = stat.merge_go ? S_SORT_CHK : S_EF_SLOT;
        end else begin
          state_next = S_RET;
        end
      end
      S_RET: begin
        cmd        = CMD_RET;
        state_next = ((stat.act == ACT_RETGET) && !stat.num_zero) ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        cmd = CMD_SCAN;
        if (stat.scan_done) begin
          priority if (stat.exact) begin
            state_next = S_EX_RD;
          end else if (stat.has_cand) begin
            state_next = S_FIT;
          end else begin
            state_next = S_NOFIT;
          end
        end
      end
      S_EX_RD: begin
        cmd        = CMD_EX_RD;
        state_next = S_EX_WR;
      end
      S_EX_WR: begin
        cmd        = CMD_EX_WR;
        state_next = S_OUT;
      end
      S_FIT: begin
        cmd        = CMD_FIT;
        state_next = S_OUT;
      end
      S_NOFIT: begin
        cmd        = CMD_NOFIT;
        state_next = S_OUT;
      end
      S_SORT_CHK: state_next = stat.i_lt_used ? S_KEY_RD : S_MG_INIT;
      S_KEY_RD: begin
        cmd        = CMD_KEY_RD;
        state_next = S_KEY_LD;
      end
      S_KEY_LD: begin
        cmd        = CMD_KEY_LD;
        state_next = S_IN_CHK;
      end
      S_IN_CHK: begin
        cmd        = CMD_IN_CHK;
        state_next = stat.j_zero ? S_SORT_CHK : S_IN_CMP;
      end
      S_IN_CMP: begin
        cmd        = CMD_IN_CMP;
        state_next = stat.shift ? S_IN_CHK : S_SORT_CHK;
      end
      S_MG_INIT: begin
        cmd        = CMD_MG_INIT;
        state_next = S_MG_LD;
      end
      S_MG_LD: begin
        cmd        = CMD_MG_LD;
        state_next = S_MG_CHK;
      end
      S_MG_CHK: begin
        cmd        = CMD_MG_CHK;
        state_next = stat.ip1_lt_used ? S_MG_CMP : S_MG_DONE;
      end
      S_MG_CMP: begin
        cmd        = CMD_MG_CMP;
        state_next = stat.mergeable ? S_SH_CHK : S_MG_CHK;
      end
      S_SH_CHK: begin
        cmd        = CMD_SH_CHK;
        state_next = stat.jp1_lt_used ? S_SH_WR : S_MG_CHK;
      end
      S_SH_WR: begin
        cmd        = CMD_SH_WR;
        state_next = S_SH_CHK;
      end
      S_MG_DONE: begin
        cmd        = CMD_MG_DONE;
        state_next = S_EF_SLOT;
      end
      S_EF_SLOT: begin
        cmd        = CMD_EF_SLOT;
        state_next = S_EF_CHK;
      end
      S_EF_CHK: begin
        cmd        = CMD_EF_CHK;
        state_next = stat.k_lt_dused ? S_EF_REL : S_OUT;
      end
      S_EF_REL: begin
        cmd        = CMD_EF_REL;
        state_next = S_EF_CHK;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd        = CMD_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/slice_free_list_allocator_top.sv
// Channel   Dir  Word
// in_ch     in   action, num_ids, slice_start, slice_length
// out_ch    out  status, granted_start, granted_length, allocated_bytes, free_count
// cfg_*     in   register index and data, one write per cycle
//
// One word at a time through a single-port free table memory. A get walks the
// table at one entry per cycle, stopping early on an exact fit or when the
// candidate limit is reached; an exact fit then also moves the last entry into
// its place. End of frame runs a memory insertion sort and a merge pass with
// shifts when the table has changed, then releases the deferred ranges of one
// ring slot. Reset and pool writes take effect at once with no clearing pass.
// A result waits in the output register; the next word is taken once it has
// been handed over to that register.
module slice_free_list_allocator_top #(
  parameter int FREE_ENTRIES   = sfla_pkg::FREE_ENTRIES_DEF,
  parameter int INDEX_BITS     = sfla_pkg::INDEX_BITS_DEF,
  parameter int RING_SLOTS     = sfla_pkg::RING_SLOTS_DEF,
  parameter int DEFERRED_DEPTH = sfla_pkg::DEFERRED_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sfla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [INDEX_BITS:0]            cfg_data,
  sfla_in_if.sink                        in_ch,
  sfla_out_if.source                     out_ch
);
  import sfla_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  // Sequencer.
  sfla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  // Tables, counters and result register.
  sfla_dp #(
    .FREE_ENTRIES   (FREE_ENTRIES),
    .INDEX_BITS     (INDEX_BITS),
    .RING_SLOTS     (RING_SLOTS),
    .DEFERRED_DEPTH (DEFERRED_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_action  (in_ch.action),
    .in_num     (in_ch.num_ids),
    .in_start   (in_ch.slice_start),
    .in_len     (in_ch.slice_length),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_gstart (out_ch.granted_start),
    .out_glen   (out_ch.granted_length),
    .out_bytes  (out_ch.allocated_bytes),
    .out_count  (out_ch.free_count)
  );

endmodule
